### rtl/oad_pkg.sv
package oad_pkg;

  // Coordinate and table sizing.
  localparam int COORD_WIDTH = 16;
  localparam int TABLE_BITS  = 7;
  localparam int MAG_W       = COORD_WIDTH;
  localparam int QUOT_W      = TABLE_BITS + 1;
  localparam int ROM_DEPTH   = (1 << TABLE_BITS) + 1;
  localparam int ANGLE_W     = 9;
  localparam int DEG_W       = 6;
  localparam int TAN_COUNT   = 45;

  // Octant base angles.
  localparam logic [ANGLE_W-1:0] BASE_0   = ANGLE_W'(0);
  localparam logic [ANGLE_W-1:0] BASE_90  = ANGLE_W'(90);
  localparam logic [ANGLE_W-1:0] BASE_180 = ANGLE_W'(180);
  localparam logic [ANGLE_W-1:0] BASE_270 = ANGLE_W'(270);
  localparam logic [ANGLE_W-1:0] BASE_360 = ANGLE_W'(360);

  // tan(d degrees) scaled by ten million, rounded, for d = 0..44.
  localparam logic [23:0] TAN_E7 [TAN_COUNT] = '{
    24'd0,       24'd174551,  24'd349208,  24'd524078,  24'd699268,  24'd874887,
    24'd1051042, 24'd1227846, 24'd1405408, 24'd1583844, 24'd1763270, 24'd1943803,
    24'd2125566, 24'd2308682, 24'd2493280, 24'd2679492, 24'd2867454, 24'd3057307,
    24'd3249197, 24'd3443276, 24'd3639702, 24'd3838640, 24'd4040262, 24'd4244748,
    24'd4452287, 24'd4663077, 24'd4877326, 24'd5095254, 24'd5317094, 24'd5543091,
    24'd5773503, 24'd6008606, 24'd6248694, 24'd6494076, 24'd6745085, 24'd7002075,
    24'd7265425, 24'd7535541, 24'd7812856, 24'd8097840, 24'd8390996, 24'd8692867,
    24'd9004040, 24'd9325151, 24'd9656888
  };

  typedef logic [ROM_DEPTH-1:0][DEG_W-1:0] atan_rom_t;

  // Entry q counts the whole degrees from 1 to 44 whose tangent does not exceed q / 2^TABLE_BITS.
  // The last entry stands for a ratio of exactly one, 45 degrees.
  function automatic atan_rom_t build_atan_rom();
    atan_rom_t      rom;
    longint unsigned lhs;
    longint unsigned rhs;
    int unsigned    deg;
    for (int q = 0; q < ROM_DEPTH; q++) begin
      deg = 0;
      if (q == (1 << TABLE_BITS)) begin
        deg = 45;
      end else begin
        for (int d = 1; d < TAN_COUNT; d++) begin
          lhs = longint'(TAN_E7[d]) * longint'(1 << TABLE_BITS);
          rhs = longint'(q) * 64'd10000000;
          if (lhs <= rhs) begin
            deg = deg + 1;
          end
        end
      end
      rom[q] = DEG_W'(deg);
    end
    return rom;
  endfunction

  localparam atan_rom_t ATAN_ROM = build_atan_rom();

  // Octant information that rides along with the division.
  typedef struct packed {
    logic               zero;
    logic               add;
    logic [ANGLE_W-1:0] base;
  } oad_meta_t;

  // One divider stage. The remainder is held already shifted for the next step.
  typedef struct packed {
    oad_meta_t         meta;
    logic [MAG_W:0]    rem;
    logic [MAG_W-1:0]  den;
    logic [QUOT_W-1:0] quot;
  } oad_div_t;

endpackage

### rtl/oad_vec_if.sv
interface oad_vec_if;
  import oad_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vec_y;
  logic signed [COORD_WIDTH-1:0] vec_x;

  modport source (output valid, output vec_y, output vec_x, input ready);
  modport sink   (input valid, input vec_y, input vec_x, output ready);
endinterface

### rtl/oad_angle_if.sv
interface oad_angle_if;
  import oad_pkg::*;

  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] angle_deg;

  modport source (output valid, output angle_deg, input ready);
  modport sink   (input valid, input angle_deg, output ready);
endinterface

### rtl/oad_prep.sv
module oad_prep (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   ready_o,
  input  logic signed [oad_pkg::COORD_WIDTH-1:0] vec_y_i,
  input  logic signed [oad_pkg::COORD_WIDTH-1:0] vec_x_i,
  output logic                                   valid_o,
  input  logic                                   ready_i,
  output oad_pkg::oad_div_t                      data_o
);
  import oad_pkg::*;

  logic             ny, nx, xbig;
  logic [MAG_W-1:0] ay, ax;
  oad_div_t         data_d, data_q;
  logic             valid_q;

  always_comb begin
    ny   = vec_y_i[COORD_WIDTH-1];
    nx   = vec_x_i[COORD_WIDTH-1];
    // Negation in unsigned form keeps the most negative value exact.
    ay   = ny ? (~MAG_W'(vec_y_i) + MAG_W'(1)) : MAG_W'(vec_y_i);
    ax   = nx ? (~MAG_W'(vec_x_i) + MAG_W'(1)) : MAG_W'(vec_x_i);
    xbig = ax > ay;

    data_d.meta.zero = (ax == '0) && (ay == '0);
    data_d.rem       = {1'b0, (xbig ? ay : ax)};
    data_d.den       = xbig ? ax : ay;
    data_d.quot      = '0;

    unique case ({nx, ny})
      2'b00: begin
        data_d.meta.base = xbig ? BASE_0 : BASE_90;
        data_d.meta.add  = xbig;
      end
      2'b01: begin
        data_d.meta.base = xbig ? BASE_360 : BASE_270;
        data_d.meta.add  = !xbig;
      end
      2'b10: begin
        data_d.meta.base = xbig ? BASE_180 : BASE_90;
        data_d.meta.add  = !xbig;
      end
      default: begin
        data_d.meta.base = xbig ? BASE_180 : BASE_270;
        data_d.meta.add  = xbig;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

### rtl/oad_div_step.sv
module oad_div_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  oad_pkg::oad_div_t data_i,
  output logic              valid_o,
  input  logic              ready_i,
  output oad_pkg::oad_div_t data_o
);
  import oad_pkg::*;

  logic             bit_set;
  logic [MAG_W:0]   diff;
  logic [MAG_W-1:0] rest;
  oad_div_t         data_d, data_q;
  logic             valid_q;

  // One restoring step: one quotient bit per stage.
  always_comb begin
    bit_set     = data_i.rem >= {1'b0, data_i.den};
    diff        = data_i.rem - {1'b0, data_i.den};
    rest        = bit_set ? diff[MAG_W-1:0] : data_i.rem[MAG_W-1:0];
    data_d      = data_i;
    data_d.rem  = {rest, 1'b0};
    data_d.quot = {data_i.quot[QUOT_W-2:0], bit_set};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

### rtl/oad_post.sv
module oad_post (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  oad_pkg::oad_div_t             data_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [oad_pkg::ANGLE_W-1:0]   angle_deg_o
);
  import oad_pkg::*;

  logic [DEG_W-1:0]   deg;
  logic [ANGLE_W-1:0] sum;
  logic [ANGLE_W-1:0] angle_d, angle_q;
  logic               valid_q;

  always_comb begin
    deg = ATAN_ROM[data_i.quot];
    sum = data_i.meta.add ? (data_i.meta.base + ANGLE_W'(deg))
                          : (data_i.meta.base - ANGLE_W'(deg));
    if (data_i.meta.zero || (sum == BASE_360)) begin
      angle_d = BASE_0;
    end else begin
      angle_d = sum;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      angle_q <= angle_d;
    end
  end

  assign valid_o     = valid_q;
  assign angle_deg_o = angle_q;
endmodule

### rtl/octant_atan2_degrees_top.sv
// Channel   Direction  Beat contents
// vec_i     in         vec_y, vec_x (signed vector components)
// angle_o   out        angle_deg (0 to 359 degrees)
//
// One beat is accepted every cycle while a stage is free or angle_o is ready;
// each result passes one stage for magnitudes and octant, one divider stage
// per quotient bit, and one stage for the ROM and the final add. Reset
// clears only the valid bits of the stages. When angle_o stalls, each stage
// holds while full and the stall reaches vec_i only once every stage is
// occupied; no beat is lost or repeated.
module octant_atan2_degrees_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  oad_vec_if.sink     vec_i,
  oad_angle_if.source angle_o
);
  import oad_pkg::*;

  // Handshake and data between the stages. Index 0 is the output of the
  // octant stage; index k is the output of divider step k.
  logic     valid_s [QUOT_W+1];
  logic     ready_s [QUOT_W+1];
  oad_div_t data_s  [QUOT_W+1];

  // Absolute values, octant, base angle and the operands of the ratio.
  oad_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vec_i.valid),
    .ready_o (vec_i.ready),
    .vec_y_i (vec_i.vec_y),
    .vec_x_i (vec_i.vec_x),
    .valid_o (valid_s[0]),
    .ready_i (ready_s[0]),
    .data_o  (data_s[0])
  );

  // Pipelined restoring divider. The first step yields the integer bit,
  // which is set only when both magnitudes are equal; the rest yield the
  // TABLE_BITS fractional bits of smaller / larger.
  for (genvar k = 0; k < QUOT_W; k++) begin : g_div
    oad_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[k]),
      .ready_o (ready_s[k]),
      .data_i  (data_s[k]),
      .valid_o (valid_s[k+1]),
      .ready_i (ready_s[k+1]),
      .data_o  (data_s[k+1])
    );
  end

  // Arctangent lookup, add to or subtract from the octant base, wrap 360
  // to 0 and force the zero vector to 0. Its register is the output register.
  oad_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_s[QUOT_W]),
    .ready_o     (ready_s[QUOT_W]),
    .data_i      (data_s[QUOT_W]),
    .valid_o     (angle_o.valid),
    .ready_i     (angle_o.ready),
    .angle_deg_o (angle_o.angle_deg)
  );
endmodule

### dv/testbench.sv
module testbench;
  import oad_pkg::*;

  // Length of the pipeline, used to size the wait after the drain.
  localparam int LATENCY      = TABLE_BITS + 3;
  localparam int RANDOM_ITEMS = 950;
  // Number of entries in the arctangent table: ratios 0 .. 2^TABLE_BITS.
  localparam int ATAN_ENTRIES = (1 << TABLE_BITS) + 1;
  // The first long receiver hold-off. It is far longer than the pipeline is
  // deep, so the block fills up and has to drop ready on its input.
  localparam int HOLD_OFF     = 120;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int REPORT_LIMIT = 10;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [ANGLE_W-1:0]            angle_t;

  // One outstanding angle, kept with the vector it came from.
  typedef struct {
    coord_t y;
    coord_t x;
    angle_t angle;
  } pending_angle_t;

  // Predicts the angle of each accepted vector and checks the angles that come
  // back against the predictions, in order.
  class angle_tracker;
    // tan(d degrees) times ten million, rounded, for d = 0..44.
    int unsigned    tan_scaled[45] = '{
      0,       174551,  349208,  524078,  699268,  874887,
      1051042, 1227846, 1405408, 1583844, 1763270, 1943803,
      2125566, 2308682, 2493280, 2679492, 2867454, 3057307,
      3249197, 3443276, 3639702, 3838640, 4040262, 4244748,
      4452287, 4663077, 4877326, 5095254, 5317094, 5543091,
      5773503, 6008606, 6248694, 6494076, 6745085, 7002075,
      7265425, 7535541, 7812856, 8097840, 8390996, 8692867,
      9004040, 9325151, 9656888
    };
    int unsigned    atan_deg[ATAN_ENTRIES];
    pending_angle_t outstanding[$];
    int             error_count;

    function new();
      int unsigned deg;
      for (int q = 0; q < ATAN_ENTRIES; q++) begin
        deg = 0;
        if (q == ATAN_ENTRIES - 1) begin
          deg = 45;
        end else begin
          for (int d = 1; d < 45; d++) begin
            if (longint'(tan_scaled[d]) * (1 << TABLE_BITS) <= longint'(q) * 10000000) begin
              deg++;
            end
          end
        end
        atan_deg[q] = deg;
      end
      error_count = 0;
    endfunction

    function angle_t octant_angle(coord_t y, coord_t x);
      int ay;
      int ax;
      int q;
      int base;
      int r;
      bit ny;
      bit nx;
      bit xbig;
      bit add;
      ny = (y < 0);
      nx = (x < 0);
      ay = ny ? -int'(y) : int'(y);
      ax = nx ? -int'(x) : int'(x);
      if (ax == 0 && ay == 0) begin
        return '0;
      end
      xbig = (ax > ay);
      q = xbig ? (ay << TABLE_BITS) / ax : (ax << TABLE_BITS) / ay;
      if (!nx && !ny) begin
        base = xbig ? 0 : 90;
        add  = xbig;
      end else if (!nx && ny) begin
        base = xbig ? 360 : 270;
        add  = !xbig;
      end else if (nx && !ny) begin
        base = xbig ? 180 : 90;
        add  = !xbig;
      end else begin
        base = xbig ? 180 : 270;
        add  = xbig;
      end
      r = add ? base + int'(atan_deg[q]) : base - int'(atan_deg[q]);
      if (r == 360) begin
        r = 0;
      end
      return angle_t'(r);
    endfunction

    function void note_vector(coord_t y, coord_t x);
      pending_angle_t p;
      p.y     = y;
      p.x     = x;
      p.angle = octant_angle(y, x);
      outstanding.push_back(p);
    endfunction

    function void check_angle(angle_t got);
      pending_angle_t p;
      if (outstanding.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("ERROR: angle %0d arrived with no vector outstanding", got);
        end
        return;
      end
      p = outstanding.pop_front();
      if (got !== p.angle) begin
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
          $display("ERROR: vector y=%0d x=%0d: expected angle %0d, got %0d",
                   p.y, p.x, p.angle, got);
        end
      end
    endfunction

    function int pending();
      return outstanding.size();
    endfunction

    // Anything still outstanding once the pipeline has drained is lost.
    function void close_out();
      if (outstanding.size() != 0) begin
        error_count += outstanding.size();
        $display("ERROR: %0d angles never arrived", outstanding.size());
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  oad_vec_if   vec_bus();
  oad_angle_if angle_bus();

  octant_atan2_degrees_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vec_i   (vec_bus),
    .angle_o (angle_bus)
  );

  angle_tracker tracker = new();

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Both channels are sampled right at the rising edge. Every input is driven
  // with nonblocking assignments, so what is seen here is the value that held
  // before the edge, which is what the block itself sees.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (vec_bus.valid && vec_bus.ready) begin
        tracker.note_vector(vec_bus.vec_y, vec_bus.vec_x);
      end
      if (angle_bus.valid && angle_bus.ready) begin
        tracker.check_angle(angle_bus.angle_deg);
      end
    end
  end

  // Offers one vector beat and returns at the edge where it is taken. The
  // caller is always at a rising edge, and valid stays high into the next
  // beat of a burst without being lowered in between.
  task automatic offer(input coord_t y, input coord_t x);
    vec_bus.valid <= 1'b1;
    vec_bus.vec_y <= y;
    vec_bus.vec_x <= x;
    do begin
      @(posedge clk_i);
    end while (!vec_bus.ready);
  endtask

  // Draws one random vector. Four in ten come from the whole range, so every bit of
  // both components toggles. The rest aim at the corners of the mapping:
  // tiny vectors where the ratio index jumps, near-diagonals where the index
  // reaches its top entry, vectors on or next to an axis (the wrap of 360 to
  // zero lives there), and the most negative and most positive components.
  task automatic random_vector(output coord_t y, output coord_t x);
    int kind;
    int m;
    int other;
    int corner_vals[7];
    corner_vals = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        y = coord_t'($urandom);
        x = coord_t'($urandom);
      end
      4: begin
        y = coord_t'($urandom_range(0, 16) - 8);
        x = coord_t'($urandom_range(0, 16) - 8);
      end
      5, 6: begin
        m     = $urandom_range(1, 32767);
        other = m + $urandom_range(0, 4) - 2;
        if (other < 0) begin
          other = 0;
        end
        if (other > 32767) begin
          other = 32767;
        end
        y = $urandom_range(0, 1) ? coord_t'(-m) : coord_t'(m);
        x = $urandom_range(0, 1) ? coord_t'(-other) : coord_t'(other);
        if ($urandom_range(0, 1)) begin
          {y, x} = {x, y};
        end
      end
      7: begin
        y = coord_t'($urandom_range(0, 2) - 1);
        x = coord_t'($urandom);
        if ($urandom_range(0, 1)) begin
          {y, x} = {x, y};
        end
      end
      8: begin
        y = coord_t'(corner_vals[$urandom_range(0, 6)]);
        x = coord_t'(corner_vals[$urandom_range(0, 6)]);
      end
      default: begin
        y = coord_t'($urandom_range(0, 255) - 128);
        x = coord_t'($urandom_range(0, 255) - 128);
      end
    endcase
  endtask

  // Receiver. It first holds ready low for a long counted stretch while the
  // sender keeps offering, so the pipeline fills and the stall reaches the
  // input. After that it moves through random spans of steady ready, random
  // stalls, fixed patterns and shorter hold-offs.
  initial begin
    int mode;
    int span;
    angle_bus.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) begin
      @(posedge clk_i);
    end
    angle_bus.ready <= 1'b0;
    for (int held = 0; held < HOLD_OFF; held++) begin
      @(posedge clk_i);
    end
    forever begin
      mode = $urandom_range(0, 9);
      span = $urandom_range(16, 96);
      for (int c = 0; c < span; c++) begin
        case (mode)
          0, 1, 2: angle_bus.ready <= 1'b1;
          3, 4:    angle_bus.ready <= 1'($urandom_range(0, 1));
          5, 6:    angle_bus.ready <= (c % 3 == 0);
          7:       angle_bus.ready <= ($urandom_range(0, 7) != 0);
          8:       angle_bus.ready <= (c >= span - 4);
          default: angle_bus.ready <= ((c / 5) % 2 == 1);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Reset, then the directed vectors, then random bursts, then the drain.
  initial begin
    int     burst;
    int     gap;
    int     sent;
    int     drain_cycles;
    coord_t y;
    coord_t x;

    rst_ni          <= 1'b0;
    vec_bus.valid   <= 1'b0;
    vec_bus.vec_y   <= '0;
    vec_bus.vec_x   <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed vectors, sent back to back. They cover the zero vector, both
    // axes in both directions, all four diagonals, the most negative
    // component on each axis, the smallest nonzero ratio in six of the eight octants, and
    // the case where the fourth-quadrant base of 360 loses nothing and wraps.
    offer(0, 0);
    offer(0, 32767);
    offer(0, -32768);
    offer(32767, 0);
    offer(-32768, 0);
    offer(100, 100);
    offer(100, -100);
    offer(-100, -100);
    offer(-100, 100);
    offer(-32768, -32768);
    offer(32767, 32767);
    offer(-32768, 32767);
    offer(32767, -32768);
    offer(1, 32767);
    offer(-1, 32767);
    offer(1, -32768);
    offer(-1, -32768);
    offer(32767, 1);
    offer(-32768, -1);
    offer(0, 1);
    offer(0, -1);
    offer(1, 0);
    offer(-1, 0);
    offer(3, 5);
    offer(12345, -23456);

    // Random part: bursts of random length. A gap of zero merges two bursts,
    // and valid then simply stays high.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        random_vector(y, x);
        offer(y, x);
        sent++;
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        vec_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    vec_bus.valid <= 1'b0;

    // Wait for every outstanding angle, then wait on so that any stray extra
    // result is caught.
    drain_cycles = 0;
    while (tracker.pending() > 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (4 * LATENCY) @(posedge clk_i);
    tracker.close_out();

    if (tracker.error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
